// File: rtl/path_interpolate_and_smooth_defines.svh
// Assertion macros shared by the path smoother checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef PATH_INTERPOLATE_AND_SMOOTH_DEFINES_SVH
`define PATH_INTERPOLATE_AND_SMOOTH_DEFINES_SVH

// Same-cycle implication, off during reset
`define PIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset
`define PIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pis_pkg.sv
// Shared types and constants of the path interpolator and smoother.
// No dependencies.
`default_nettype none
package pis_pkg;

	localparam int COORD_BITS            = 32;
	localparam int MAX_HALF_WINDOW_DEF   = 15;
	localparam int MAX_INTERMEDIATES_DEF = 15;

	// register map (index = byte address / 4)
	localparam int ICOUNT_BITS = 4;
	localparam int SWIN_BITS   = 5;
	localparam logic REG_ICOUNT = 1'b0;
	localparam logic REG_SWIN   = 1'b1;

	localparam int POS_BITS = 6;
	localparam logic [POS_BITS-1:0] POS_SAT = 6'd63;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
		logic signed [COORD_BITS-1:0] coord_z;
		logic                         final_point;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_z;
		logic                         path_end;
	} point_out_t;

endpackage
`default_nettype wire

// File: rtl/path_interpolate_and_smooth.sv
// Path interpolator and centered moving-average smoother (top level).
// Each inserted point costs 3 divides (DW = 37 by default); each result reads and accumulates
// its window entries (ST_ERD, ST_EACC) plus 3 more divides, all on one serial divider.
// A waypoint inserts up to 15 points; src_stall is high until it is done, including
// any dst_stall time.
// arst_n clears control state and config; window RAM contents stay undefined.
`default_nettype none
module path_interpolate_and_smooth #(
	parameter int MAX_HALF_WINDOW   = pis_pkg::MAX_HALF_WINDOW_DEF,
	parameter int MAX_INTERMEDIATES = pis_pkg::MAX_INTERMEDIATES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               src_valid,
	output logic                    src_stall,
	input  wire pis_pkg::point_in_t src_data,
	output logic                    dst_valid,
	input  wire logic               dst_stall,
	output pis_pkg::point_out_t     dst_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int W    = pis_pkg::COORD_BITS;
	localparam int RING = 2 * MAX_HALF_WINDOW + 1;
	localparam int AW   = $clog2(RING);
	localparam int PW   = $clog2(RING + 1);
	localparam int HW   = $clog2(MAX_HALF_WINDOW + 1);
	localparam int NW   = $clog2(MAX_INTERMEDIATES + 1);
	localparam int DMAX = (MAX_INTERMEDIATES + 1 > RING) ? MAX_INTERMEDIATES + 1 : RING;
	localparam int DVW  = $clog2(DMAX + 1);
	localparam int DW   = W + DVW;
	localparam int PB   = pis_pkg::POS_BITS;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_IDIV  = 4'd1;
	localparam logic [3:0] ST_IWAIT = 4'd2;
	localparam logic [3:0] ST_IPUSH = 4'd3;
	localparam logic [3:0] ST_CPUSH = 4'd4;
	localparam logic [3:0] ST_DRAIN = 4'd5;
	localparam logic [3:0] ST_ESET  = 4'd6;
	localparam logic [3:0] ST_ERD   = 4'd7;
	localparam logic [3:0] ST_EACC  = 4'd8;
	localparam logic [3:0] ST_EDIV  = 4'd9;
	localparam logic [3:0] ST_EWAIT = 4'd10;
	localparam logic [3:0] ST_EOUT  = 4'd11;
	localparam logic [3:0] ST_FLUSH = 4'd12;

	// config registers
	logic [pis_pkg::ICOUNT_BITS-1:0] icount_q;
	logic [pis_pkg::SWIN_BITS-1:0]   swin_q;
	logic                            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == pis_pkg::REG_SWIN) ? 32'(swin_q) : 32'(icount_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icount_q <= '0;
			swin_q   <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == pis_pkg::REG_SWIN) begin
				swin_q <= pwdata[pis_pkg::SWIN_BITS-1:0];
			end else begin
				icount_q <= pwdata[pis_pkg::ICOUNT_BITS-1:0];
			end
		end
	end

	logic [NW-1:0] n_cap;
	logic [HW-1:0] h_cap;
	assign n_cap = (32'(icount_q) > MAX_INTERMEDIATES) ? NW'(MAX_INTERMEDIATES) : NW'(icount_q);
	assign h_cap = (32'(swin_q[pis_pkg::SWIN_BITS-1:1]) > MAX_HALF_WINDOW) ?
		HW'(MAX_HALF_WINDOW) : HW'(swin_q[pis_pkg::SWIN_BITS-1:1]);

	// sequencer and datapath state
	logic [3:0]             state_q;
	logic signed [W-1:0]    cur_q  [0:2];
	logic signed [W-1:0]    prev_q [0:2];
	logic signed [W:0]      diff_q [0:2];
	logic signed [DW:0]     acc_q  [0:2];
	logic signed [W-1:0]    pt_q   [0:2];
	logic signed [DW:0]     sum_q  [0:2];
	logic signed [W-1:0]    res_q  [0:2];
	logic                   fin_q, raw_q, last_q, wc_q, pushed_q, ret_flush_q;
	logic [NW-1:0]          j_q;
	logic [AW-1:0]          wi_q, rp_q;
	logic [PW-1:0]          pend_q;
	logic [PB-1:0]          pos_q;
	logic [DVW-1:0]         k_q, cnt_q;
	logic [1:0]             ax_q;
	logic                   dst_valid_q;
	pis_pkg::point_out_t    dst_q;

	// window span for the next result
	logic [HW-1:0]   back, fwd;
	logic [PW-1:0]   pm1;
	logic [AW+1:0]   st_w;
	logic [AW-1:0]   rp_start;
	logic [DVW-1:0]  count;
	logic            drain_go;
	logic            out_free;
	logic            emit_fire;

	assign pm1  = pend_q - 1'b1;
	assign back = raw_q ? '0 : ((32'(pos_q) < 32'(h_cap)) ? HW'(pos_q) : h_cap);
	assign fwd  = raw_q ? '0 : ((32'(pm1) < 32'(h_cap)) ? HW'(pm1) : h_cap);
	assign count = DVW'(back) + DVW'(fwd) + DVW'(1);
	assign st_w = (AW+2)'(wi_q) + (AW+2)'(RING) - (AW+2)'(pend_q) - (AW+2)'(back);
	assign rp_start = (st_w >= (AW+2)'(RING)) ? AW'(st_w - (AW+2)'(RING)) : AW'(st_w);
	assign drain_go = (32'(pend_q) > 32'(h_cap)) && ((pos_q != '0) || (32'(pend_q) >= 3));
	assign out_free = !dst_valid_q || !dst_stall;
	assign emit_fire = (state_q == ST_EOUT) && out_free;

	// shared divider
	logic               div_start, div_done;
	logic signed [DW:0] div_a, div_q;
	logic [DVW-1:0]     div_b;

	assign div_start = (state_q == ST_IDIV) || (state_q == ST_EDIV);
	assign div_a     = (state_q == ST_IDIV) ? acc_q[ax_q] : sum_q[ax_q];
	assign div_b     = (state_q == ST_IDIV) ? DVW'(n_cap) + DVW'(1) : cnt_q;

	pis_div #(.DW(DW), .DVW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// window ring
	logic            ram_we, ram_re;
	logic [3*W-1:0]  ram_wdata, ram_rdata;

	assign ram_we    = (state_q == ST_IPUSH) || (state_q == ST_CPUSH);
	assign ram_re    = (state_q == ST_ERD);
	assign ram_wdata = (state_q == ST_IPUSH) ? {pt_q[2], pt_q[1], pt_q[0]} :
		{cur_q[2], cur_q[1], cur_q[0]};

	pis_ram #(.WIDTH(3 * W), .DEPTH(RING)) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wi_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wc_q        <= 1'b0;
			pushed_q    <= 1'b0;
			fin_q       <= 1'b0;
			raw_q       <= 1'b0;
			last_q      <= 1'b0;
			ret_flush_q <= 1'b0;
			j_q         <= '0;
			wi_q        <= '0;
			rp_q        <= '0;
			pend_q      <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			ax_q        <= '0;
			dst_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			// output register: load on a result, clear once taken
			if (emit_fire) begin
				dst_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				dst_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						fin_q    <= src_data.final_point;
						pushed_q <= 1'b0;
						j_q      <= NW'(1);
						ax_q     <= '0;
						state_q  <= (wc_q && n_cap != '0) ? ST_IDIV : ST_CPUSH;
					end
				end
				ST_IDIV: begin
					state_q <= ST_IWAIT;
				end
				ST_IWAIT: begin
					if (div_done) begin
						ax_q    <= ax_q + 1'b1;
						state_q <= (ax_q == 2'd2) ? ST_IPUSH : ST_IDIV;
					end
				end
				ST_IPUSH, ST_CPUSH: begin
					wi_q    <= (32'(wi_q) == RING - 1) ? '0 : wi_q + 1'b1;
					pend_q  <= pend_q + 1'b1;
					if (state_q == ST_CPUSH) begin
						pushed_q <= 1'b1;
					end
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (drain_go) begin
						raw_q       <= 1'b0;
						last_q      <= 1'b0;
						ret_flush_q <= 1'b0;
						state_q     <= ST_ESET;
					end else if (!pushed_q) begin
						if (j_q < n_cap) begin
							j_q     <= j_q + 1'b1;
							ax_q    <= '0;
							state_q <= ST_IDIV;
						end else begin
							state_q <= ST_CPUSH;
						end
					end else begin
						for (int i = 0; i < 3; i++) begin
							prev_q[i] <= cur_q[i];
						end
						wc_q <= 1'b1;
						if (fin_q) begin
							raw_q   <= (pos_q == '0) && (32'(pend_q) <= 2);
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (pend_q != '0) begin
						last_q      <= (pend_q == PW'(1));
						ret_flush_q <= 1'b1;
						state_q     <= ST_ESET;
					end else begin
						pos_q   <= '0;
						wc_q    <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_ESET: begin
					rp_q    <= rp_start;
					cnt_q   <= count;
					k_q     <= '0;
					state_q <= ST_ERD;
				end
				ST_ERD: begin
					state_q <= ST_EACC;
				end
				ST_EACC: begin
					rp_q <= (32'(rp_q) == RING - 1) ? '0 : rp_q + 1'b1;
					k_q  <= k_q + 1'b1;
					if (k_q == cnt_q - DVW'(1)) begin
						ax_q    <= '0;
						state_q <= ST_EDIV;
					end else begin
						state_q <= ST_ERD;
					end
				end
				ST_EDIV: begin
					state_q <= ST_EWAIT;
				end
				ST_EWAIT: begin
					if (div_done) begin
						ax_q    <= ax_q + 1'b1;
						state_q <= (ax_q == 2'd2) ? ST_EOUT : ST_EDIV;
					end
				end
				ST_EOUT: begin
					if (out_free) begin
						pend_q      <= pend_q - 1'b1;
						if (pos_q != pis_pkg::POS_SAT) begin
							pos_q <= pos_q + 1'b1;
						end
						state_q <= ret_flush_q ? ST_FLUSH : ST_DRAIN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && src_valid) begin
			cur_q[0]  <= src_data.coord_x;
			cur_q[1]  <= src_data.coord_y;
			cur_q[2]  <= src_data.coord_z;
			diff_q[0] <= (W+1)'(src_data.coord_x) - (W+1)'(prev_q[0]);
			diff_q[1] <= (W+1)'(src_data.coord_y) - (W+1)'(prev_q[1]);
			diff_q[2] <= (W+1)'(src_data.coord_z) - (W+1)'(prev_q[2]);
			acc_q[0]  <= (DW+1)'((W+1)'(src_data.coord_x) - (W+1)'(prev_q[0]));
			acc_q[1]  <= (DW+1)'((W+1)'(src_data.coord_y) - (W+1)'(prev_q[1]));
			acc_q[2]  <= (DW+1)'((W+1)'(src_data.coord_z) - (W+1)'(prev_q[2]));
		end
		// next multiple j*diff
		if (state_q == ST_DRAIN && !drain_go && !pushed_q && j_q < n_cap) begin
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= acc_q[i] + (DW+1)'(diff_q[i]);
			end
		end
		if (state_q == ST_IWAIT && div_done) begin
			pt_q[ax_q] <= prev_q[ax_q] + W'(div_q);
		end
		if (state_q == ST_ESET) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
			end
		end
		if (state_q == ST_EACC) begin
			sum_q[0] <= sum_q[0] + (DW+1)'($signed(ram_rdata[W-1:0]));
			sum_q[1] <= sum_q[1] + (DW+1)'($signed(ram_rdata[2*W-1:W]));
			sum_q[2] <= sum_q[2] + (DW+1)'($signed(ram_rdata[3*W-1:2*W]));
		end
		if (state_q == ST_EWAIT && div_done) begin
			res_q[ax_q] <= W'(div_q);
		end
		if (emit_fire) begin
			dst_q.out_x    <= res_q[0];
			dst_q.out_y    <= res_q[1];
			dst_q.out_z    <= res_q[2];
			dst_q.path_end <= last_q;
		end
	end

	assign src_stall = (state_q != ST_IDLE);
	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_q;

endmodule
`default_nettype wire

// File: rtl/pis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module pis_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 31
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/pis_div.sv
// Shared restoring divider: signed dividend by small positive divisor,
// quotient truncated toward zero, one quotient bit per cycle. No dependencies.
`default_nettype none
module pis_div #(
	parameter int DW  = 37,
	parameter int DVW = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic signed [DW:0] dividend,
	input  wire logic [DVW-1:0]    divisor,
	output logic                   done,
	output logic signed [DW:0]     quotient
);

	localparam int CW = $clog2(DW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic              neg_q;
	logic [DW-1:0]     mag_q;
	logic [DVW-1:0]    rem_q;
	logic [DVW-1:0]    dvs_q;
	logic [DVW:0]      shifted;
	logic              fits;

	assign shifted = {rem_q, mag_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitude datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW];
			mag_q <= dividend[DW] ? DW'(-dividend) : DW'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVW'(shifted - {1'b0, dvs_q}) : DVW'(shifted);
			mag_q <= {mag_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule
`default_nettype wire

// File: rtl/pis_check.sv
// Port-level checker for the path smoother, bound to the top level.
// Depends on pis_pkg and path_interpolate_and_smooth_defines.svh.
`default_nettype none
`include "path_interpolate_and_smooth_defines.svh"
module pis_check (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                src_valid,
	input wire logic                src_stall,
	input wire logic                dst_valid,
	input wire logic                dst_stall,
	input wire pis_pkg::point_out_t dst_data
);

	// a held result keeps its payload
	`PIS_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_data), "result changed while stalled")
	// the block is busy right after taking a waypoint
	`PIS_ASSERT_NEXT(a_busy_after_take, src_valid && !src_stall, src_stall, "input taken back to back")
	// results are produced only by a waypoint in progress
	`PIS_ASSERT_NOW(a_out_from_work, $rose(dst_valid), $past(src_stall), "result appeared while idle")

endmodule

bind path_interpolate_and_smooth pis_check u_pis_check (.*);
`default_nettype wire
